### rtl/neighbor_edge_table_macros.svh
// Assertion macros for the neighbor edge table checker.
// Every macro samples on aclk; the first two are disabled while aresetn is low.
`ifndef NEIGHBOR_EDGE_TABLE_MACROS_SVH
`define NEIGHBOR_EDGE_TABLE_MACROS_SVH

// Same-cycle implication, ignored during reset
`define NBT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored during reset
`define NBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define NBT_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/nbt_pkg.sv
// Shared types and constants for the neighbor edge table.
// Used by neighbor_edge_table and its checker; no dependencies.
package nbt_pkg;

    // Field widths of the stream payloads
    localparam int ADDR_W   = 48;
    localparam int WEIGHT_W = 16;
    localparam int TIME_W   = 32;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 24;
    localparam int M_PAD_W  = M_DATA_W - INDEX_W - 2 - 2 * COUNT_W;

    // Operation kinds carried on s_tuser
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_PURGE  = 1'b1;

    // One stored link; also the input beat layout (key lowest)
    typedef struct packed {
        logic [TIME_W-1:0]   stamp;
        logic [WEIGHT_W-1:0] weight;
        logic [ADDR_W-1:0]   key;
    } nbt_entry_t;

    // Result beat layout, entry_index in the lowest bits
    typedef struct packed {
        logic [M_PAD_W-1:0] pad;
        logic [COUNT_W-1:0] entry_count;
        logic [COUNT_W-1:0] removed_count;
        logic               table_full;
        logic               was_new;
        logic [INDEX_W-1:0] entry_index;
    } nbt_result_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_USCAN,
        ST_PFETCH,
        ST_PCHECK,
        ST_PMOVE,
        ST_FINISH
    } nbt_state_t;

endpackage

### rtl/neighbor_edge_table.sv
// Neighbor edge table: a packed link table held in one synchronous RAM.
// An update searches for the address and refreshes or appends the entry; a purge drops old
// entries by moving the last entry into the freed slot. Depends on nbt_pkg.
//
// One operation at a time; s_tready is high only between operations, while a finished
// result may still wait in the output register. The single read port of the table RAM sets
// the pace: an update reads one entry per cycle from the registered RAM read, then does the
// write and the hand-off, and stops early when the address is found. A purge checks each
// entry in turn; a removed entry takes an extra read of the last entry, then the move into
// the freed slot. A moved entry is examined again in place. A miss on a full table is
// dropped and flagged with table_full.
// Table contents are not cleared at reset; only slots below the entry count are ever read.
module neighbor_edge_table
    import nbt_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input beats
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // neighbor_addr[47:0], link_weight[63:48],
                                           // time_value[95:64]
    input  logic                s_tuser,   // opcode[0]
    // result beats
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // entry_index[5:0], was_new[6], table_full[7],
                                           // removed_count[14:8], entry_count[21:15], pad
);

    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDX_W = $clog2(MAX_NEIGHBORS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NEIGHBORS);

    // Table RAM and its registered read data
    nbt_entry_t table_mem [MAX_NEIGHBORS];
    nbt_entry_t rd_data_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    nbt_entry_t       mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    // Control state
    nbt_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_reg, pend_next;      // a search read is in flight
    logic             m_tvalid_reg, m_tvalid_next;

    // Operation and scan registers
    nbt_entry_t       req_reg, req_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;        // next slot to read in a search
    logic [IDX_W-1:0] pidx_reg, pidx_next;      // slot of the read in flight
    logic [CNT_W-1:0] k_reg, k_next;            // purge cursor
    logic [CNT_W-1:0] removed_reg, removed_next;

    // Result being built, and the output register
    logic [IDX_W-1:0] res_index_reg, res_index_next;
    logic             res_new_reg, res_new_next;
    logic             res_full_reg, res_full_next;
    nbt_result_t      m_data_reg, m_data_next;

    // Shared conditions
    logic             s_accept;
    logic             hit;
    logic             scan_done;
    logic             older;
    logic [CNT_W-1:0] last_slot;
    logic [CNT_W-1:0] k_inc;
    logic             k_is_last;
    logic             k_more;
    logic             res_free;

    assign s_accept  = s_tvalid && s_tready;
    assign hit       = pend_reg && (rd_data_reg.key == req_reg.key);
    assign scan_done = !pend_reg && (ptr_reg == count_reg);
    assign older     = rd_data_reg.stamp < req_reg.stamp;
    assign last_slot = count_reg - 1'b1;
    assign k_inc     = k_reg + 1'b1;
    assign k_is_last = k_reg == last_slot;
    assign k_more    = k_inc < count_reg;
    assign res_free  = !m_tvalid_reg || m_tready;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // Table RAM: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= table_mem[mem_raddr];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == OP_PURGE) ? ST_PFETCH : ST_USCAN;
                end
            end
            ST_USCAN: begin
                if (hit || scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_PFETCH: begin
                state_next = (k_reg < count_reg) ? ST_PCHECK : ST_FINISH;
            end
            ST_PCHECK: begin
                priority if (older) begin
                    state_next = ST_PMOVE;
                end else if (k_more) begin
                    state_next = ST_PCHECK;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_PMOVE: begin
                state_next = k_is_last ? ST_FINISH : ST_PCHECK;
            end
            ST_FINISH: begin
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, RAM control and result
    always_comb begin
        count_next     = count_reg;
        pend_next      = pend_reg;
        req_next       = req_reg;
        ptr_next       = ptr_reg;
        pidx_next      = pidx_reg;
        k_next         = k_reg;
        removed_next   = removed_reg;
        res_index_next = res_index_reg;
        res_new_next   = res_new_reg;
        res_full_next  = res_full_reg;
        m_data_next    = m_data_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = req_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_next       = nbt_entry_t'(s_tdata);
                    ptr_next       = '0;
                    pend_next      = 1'b0;
                    k_next         = '0;
                    removed_next   = '0;
                    res_index_next = '0;
                    res_new_next   = 1'b0;
                    res_full_next  = 1'b0;
                end
            end
            ST_USCAN: begin
                priority if (hit) begin
                    // refresh in place, keep the stored key
                    mem_we           = 1'b1;
                    mem_waddr        = pidx_reg;
                    mem_wdata.key    = rd_data_reg.key;
                    res_index_next   = pidx_reg;
                    pend_next        = 1'b0;
                end else if (scan_done) begin
                    // miss: append or drop
                    if (count_reg < MAX_CNT) begin
                        mem_we         = 1'b1;
                        mem_waddr      = count_reg[IDX_W-1:0];
                        count_next     = count_reg + 1'b1;
                        res_index_next = count_reg[IDX_W-1:0];
                        res_new_next   = 1'b1;
                    end else begin
                        res_full_next  = 1'b1;
                    end
                end else begin
                    // keep one read in flight per cycle
                    if (ptr_reg < count_reg) begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_reg[IDX_W-1:0];
                        pend_next = 1'b1;
                        pidx_next = ptr_reg[IDX_W-1:0];
                        ptr_next  = ptr_reg + 1'b1;
                    end else begin
                        pend_next = 1'b0;
                    end
                end
            end
            ST_PFETCH: begin
                if (k_reg < count_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = k_reg[IDX_W-1:0];
                end
            end
            ST_PCHECK: begin
                if (older) begin
                    // fetch the last entry to fill the hole
                    mem_re    = 1'b1;
                    mem_raddr = last_slot[IDX_W-1:0];
                end else begin
                    k_next = k_inc;
                    if (k_more) begin
                        mem_re    = 1'b1;
                        mem_raddr = k_inc[IDX_W-1:0];
                    end
                end
            end
            ST_PMOVE: begin
                // rd_data_reg holds the last entry and stays for the recheck
                mem_we       = 1'b1;
                mem_waddr    = k_reg[IDX_W-1:0];
                mem_wdata    = rd_data_reg;
                count_next   = last_slot;
                removed_next = removed_reg + 1'b1;
            end
            ST_FINISH: begin
                if (res_free) begin
                    m_tvalid_next             = 1'b1;
                    m_data_next.pad           = '0;
                    m_data_next.entry_index   = INDEX_W'(res_index_reg);
                    m_data_next.was_new       = res_new_reg;
                    m_data_next.table_full    = res_full_reg;
                    m_data_next.removed_count = COUNT_W'(removed_reg);
                    m_data_next.entry_count   = COUNT_W'(count_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        ptr_reg       <= ptr_next;
        pidx_reg      <= pidx_next;
        k_reg         <= k_next;
        removed_reg   <= removed_next;
        res_index_reg <= res_index_next;
        res_new_reg   <= res_new_next;
        res_full_reg  <= res_full_next;
        m_data_reg    <= m_data_next;
    end

endmodule

### rtl/nbt_checker.sv
// Port-level checker for neighbor_edge_table, bound to the top level.
// Depends on nbt_pkg and neighbor_edge_table_macros.svh.
`include "neighbor_edge_table_macros.svh"

module nbt_checker
    import nbt_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 64
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    nbt_result_t res;
    assign res = nbt_result_t'(m_tdata);

    // a stalled result beat holds
    `NBT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    // one operation at a time
    `NBT_ASSERT_NEXT(a_one_op, s_tvalid && s_tready, !s_tready, "input taken while an operation runs")
    // insert, drop and purge results exclude each other
    `NBT_ASSERT_IMPL(a_kinds, m_tvalid && (res.was_new || res.table_full), !(res.was_new && res.table_full) && (res.removed_count == '0), "mixed result kinds")
    // a drop only happens on a full table and reports slot zero
    `NBT_ASSERT_IMPL(a_drop, m_tvalid && res.table_full, (res.entry_count == COUNT_W'(MAX_NEIGHBORS)) && (res.entry_index == '0), "drop without full table")
    // reset empties the output register
    `NBT_ASSERT_RST(a_reset, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind neighbor_edge_table nbt_checker #(
    .MAX_NEIGHBORS(MAX_NEIGHBORS)
) u_nbt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
